// ===== sv/tta_pkg.sv =====
// Shared types, constants and helpers of the triangle tangent accumulator.
`default_nettype none
package tta_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = 10;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRI  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TRI,
    CMD_READ,
    CMD_ZERO
  } cmd_op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
  } vertex_t;

  typedef struct packed {
    logic                     flag;
    logic signed [DATA_W-1:0] tx;
    logic signed [DATA_W-1:0] ty;
    logic signed [DATA_W-1:0] tz;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] bz;
  } acc_t;

  typedef struct packed {
    cmd_op_e          op;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    vertex_t          vtx;
  } cmd_t;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/tta_front.sv =====
// Front end: accepts request transactions, classifies them and queues commands.
`default_nettype none
module tta_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [tta_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [tta_pkg::IDX_W-1:0]    vertex_index_i,
  input  wire logic [tta_pkg::IDX_W-1:0]    corner_two_i,
  input  wire logic [tta_pkg::IDX_W-1:0]    corner_three_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0] position_x_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0] position_y_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0] position_z_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0] tex_u_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0] tex_v_i,
  output tta_pkg::cmd_t                     cmd_o,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_pop_i
);

  tta_pkg::cmd_t                 queue_q [tta_pkg::QUEUE_DEPTH];
  logic [tta_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tta_pkg::QPTR_W:0]      count_q, count_d;
  tta_pkg::cmd_t                 cmd;
  logic                          keep, in_a, in_b, in_c, enq, deq;

  always_comb begin
    in_a = 32'(vertex_index_i) < tta_pkg::VERTEX_COUNT;
    in_b = 32'(corner_two_i) < tta_pkg::VERTEX_COUNT;
    in_c = 32'(corner_three_i) < tta_pkg::VERTEX_COUNT;
    cmd.idx_a  = vertex_index_i;
    cmd.idx_b  = corner_two_i;
    cmd.idx_c  = corner_three_i;
    cmd.vtx.px = position_x_i;
    cmd.vtx.py = position_y_i;
    cmd.vtx.pz = position_z_i;
    cmd.vtx.u  = tex_u_i;
    cmd.vtx.v  = tex_v_i;
    cmd.op     = tta_pkg::CMD_LOAD;
    keep       = 1'b0;
    case (req_type_i)
      tta_pkg::REQ_LOAD: begin
        cmd.op = tta_pkg::CMD_LOAD;
        keep   = in_a;
      end
      tta_pkg::REQ_TRI: begin
        cmd.op = tta_pkg::CMD_TRI;
        keep   = in_a && in_b && in_c;
      end
      tta_pkg::REQ_READ: begin
        cmd.op = in_a ? tta_pkg::CMD_READ : tta_pkg::CMD_ZERO;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full        = count_q == (tta_pkg::QPTR_W+1)'(tta_pkg::QUEUE_DEPTH);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = queue_q[rd_ptr_q];
  assign enq         = push && !full && keep;
  assign deq         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    count_d = count_q;
    if (enq && !deq) begin
      count_d = count_q + 1'b1;
    end else if (deq && !enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tta_div.sv =====
// Bit-serial divider: Q32.32 numerator over Q32.32 determinant to saturated Q16.16.
`default_nettype none
module tta_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [64:0]                 num_i,
  input  wire logic signed [64:0]                 den_i,
  output logic                                    done_o,
  output logic signed [tta_pkg::DATA_W-1:0]       quo_o
);

  logic        run_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] den_q;
  logic [32:0] bits_q, quo_q;
  logic signed [tta_pkg::DATA_W-1:0] res_q;

  logic [64:0] nabs, dabs, trial;
  logic        big, qbit;
  logic [32:0] quo_next;

  always_comb begin
    nabs     = num_i[64] ? -num_i : num_i;
    dabs     = den_i[64] ? -den_i : den_i;
    big      = {17'b0, nabs[63:0]} >= {dabs[63:0], 17'b0};
    trial    = {rem_q[63:0], bits_q[32]};
    qbit     = trial >= {1'b0, den_q};
    quo_next = {quo_q[31:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (big) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= 6'd33;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[64] != den_i[64];
      den_q  <= dabs[63:0];
      rem_q  <= 65'(nabs[63:17]);
      bits_q <= {nabs[16:0], 16'b0};
      quo_q  <= '0;
      res_q  <= (num_i[64] != den_i[64]) ? tta_pkg::Q_MIN : tta_pkg::Q_MAX;
    end else if (run_q) begin
      rem_q  <= qbit ? trial - {1'b0, den_q} : trial;
      bits_q <= {bits_q[31:0], 1'b0};
      quo_q  <= quo_next;
      if (cnt_q == 6'd1) begin
        if (neg_q) begin
          res_q <= (quo_next > 33'h080000000) ? tta_pkg::Q_MIN : -quo_next[31:0];
        end else begin
          res_q <= (quo_next > 33'h07FFFFFFF) ? tta_pkg::Q_MAX : quo_next[31:0];
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule
`default_nettype wire

// ===== sv/tta_back.sv =====
// Back end: vertex and accumulator stores, triangle sequencer and result register.
`default_nettype none
module tta_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tta_pkg::cmd_t     cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output logic                   empty,
  input  wire logic              pop,
  output tta_pkg::acc_t          res_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDA    = 4'd1;
  localparam logic [3:0] ST_RDB    = 4'd2;
  localparam logic [3:0] ST_RDC    = 4'd3;
  localparam logic [3:0] ST_RDD    = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_DIVGO  = 4'd6;
  localparam logic [3:0] ST_DIVW   = 4'd7;
  localparam logic [3:0] ST_ACCRD  = 4'd8;
  localparam logic [3:0] ST_ACCWR  = 4'd9;
  localparam logic [3:0] ST_RDWAIT = 4'd10;

  localparam int W = tta_pkg::DATA_W;

  tta_pkg::vertex_t vtx_mem [tta_pkg::VERTEX_COUNT];
  tta_pkg::acc_t    acc_mem [tta_pkg::VERTEX_COUNT];

  logic [3:0]                state_q, state_d;
  logic [tta_pkg::IDX_W-1:0] idx_q [3];
  logic [tta_pkg::IDX_W-1:0] vtx_raddr, vtx_waddr, acc_raddr, acc_waddr;
  logic                      vtx_we, acc_we;
  tta_pkg::vertex_t          vtx_wdata, vtx_rdata_q, va_q;
  tta_pkg::acc_t             acc_wdata, acc_rdata_q, out_q;
  logic                      out_valid_q;

  logic signed [W-1:0]  dp1_q [3];
  logic signed [W-1:0]  dp2_q [3];
  logic signed [W-1:0]  du1_q, dv1_q, du2_q, dv2_q;
  logic [3:0]           m_q, step;
  logic signed [W-1:0]  op_a, op_b;
  logic signed [63:0]   prod_q, first_q;
  logic signed [64:0]   term_q [7];
  logic [2:0]           j_q;
  logic [1:0]           k_q;
  logic signed [W-1:0]  res_q [6];
  logic                 deg_q;
  logic                 div_start, div_done;
  logic signed [W-1:0]  div_quo;

  tta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (term_q[j_q + 3'd1]),
    .den_i   (term_q[0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign div_start = state_q == ST_DIVGO;
  assign empty     = !out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    case (m_q)
      4'd0:    begin op_a = du1_q;    op_b = dv2_q; end
      4'd1:    begin op_a = dv1_q;    op_b = du2_q; end
      4'd2:    begin op_a = dp1_q[0]; op_b = dv2_q; end
      4'd3:    begin op_a = dp2_q[0]; op_b = dv1_q; end
      4'd4:    begin op_a = dp1_q[1]; op_b = dv2_q; end
      4'd5:    begin op_a = dp2_q[1]; op_b = dv1_q; end
      4'd6:    begin op_a = dp1_q[2]; op_b = dv2_q; end
      4'd7:    begin op_a = dp2_q[2]; op_b = dv1_q; end
      4'd8:    begin op_a = dp2_q[0]; op_b = du1_q; end
      4'd9:    begin op_a = dp1_q[0]; op_b = du2_q; end
      4'd10:   begin op_a = dp2_q[1]; op_b = du1_q; end
      4'd11:   begin op_a = dp1_q[1]; op_b = du2_q; end
      4'd12:   begin op_a = dp2_q[2]; op_b = du1_q; end
      4'd13:   begin op_a = dp1_q[2]; op_b = du2_q; end
      default: begin op_a = '0;       op_b = '0;    end
    endcase
    step = m_q - 4'd1;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    vtx_we    = 1'b0;
    vtx_waddr = cmd_i.idx_a;
    vtx_wdata = cmd_i.vtx;
    vtx_raddr = idx_q[0];
    acc_we    = 1'b0;
    acc_waddr = cmd_i.idx_a;
    acc_wdata = '0;
    acc_raddr = cmd_i.idx_a;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            tta_pkg::CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              vtx_we    = 1'b1;
              acc_we    = 1'b1;
            end
            tta_pkg::CMD_TRI: begin
              cmd_pop_o = 1'b1;
              state_d   = ST_RDA;
            end
            tta_pkg::CMD_READ: begin
              if (!out_valid_q) begin
                cmd_pop_o = 1'b1;
                state_d   = ST_RDWAIT;
              end
            end
            default: begin
              cmd_pop_o = !out_valid_q;
            end
          endcase
        end
      end
      ST_RDA:    state_d = ST_RDB;
      ST_RDB: begin
        vtx_raddr = idx_q[1];
        state_d   = ST_RDC;
      end
      ST_RDC: begin
        vtx_raddr = idx_q[2];
        state_d   = ST_RDD;
      end
      ST_RDD:    state_d = ST_MUL;
      ST_MUL: begin
        if (m_q == 4'd14) begin
          state_d = (term_q[0] == '0) ? ST_ACCRD : ST_DIVGO;
        end
      end
      ST_DIVGO:  state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_d = (j_q == 3'd5) ? ST_ACCRD : ST_DIVGO;
        end
      end
      ST_ACCRD: begin
        acc_raddr = idx_q[k_q];
        state_d   = ST_ACCWR;
      end
      ST_ACCWR: begin
        acc_we    = 1'b1;
        acc_waddr = idx_q[k_q];
        acc_wdata = acc_rdata_q;
        if (deg_q) begin
          acc_wdata.flag = 1'b1;
        end else begin
          acc_wdata.tx = tta_pkg::sat_add(acc_rdata_q.tx, res_q[0]);
          acc_wdata.ty = tta_pkg::sat_add(acc_rdata_q.ty, res_q[1]);
          acc_wdata.tz = tta_pkg::sat_add(acc_rdata_q.tz, res_q[2]);
          acc_wdata.bx = tta_pkg::sat_add(acc_rdata_q.bx, res_q[3]);
          acc_wdata.by = tta_pkg::sat_add(acc_rdata_q.by, res_q[4]);
          acc_wdata.bz = tta_pkg::sat_add(acc_rdata_q.bz, res_q[5]);
        end
        state_d = (k_q == 2'd2) ? ST_IDLE : ST_ACCRD;
      end
      ST_RDWAIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      m_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_IDLE && cmd_valid_i && cmd_i.op == tta_pkg::CMD_ZERO
           && !out_valid_q) || state_q == ST_RDWAIT) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == ST_RDD) begin
        m_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (state_q == ST_MUL) begin
        m_q <= m_q + 1'b1;
      end
      if (state_q == ST_DIVW && div_done) begin
        j_q <= j_q + 1'b1;
      end
      if (state_q == ST_ACCWR) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_rdata_q <= vtx_mem[vtx_raddr];
    acc_rdata_q <= acc_mem[acc_raddr];
    if (vtx_we) begin
      vtx_mem[vtx_waddr] <= vtx_wdata;
    end
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      idx_q[0] <= cmd_i.idx_a;
      idx_q[1] <= cmd_i.idx_b;
      idx_q[2] <= cmd_i.idx_c;
      if (cmd_i.op == tta_pkg::CMD_ZERO && !out_valid_q) begin
        out_q <= '0;
      end
    end
    if (state_q == ST_RDWAIT) begin
      out_q <= acc_rdata_q;
    end
    if (state_q == ST_RDB) begin
      va_q <= vtx_rdata_q;
    end
    if (state_q == ST_RDC) begin
      dp1_q[0] <= tta_pkg::sat_sub(vtx_rdata_q.px, va_q.px);
      dp1_q[1] <= tta_pkg::sat_sub(vtx_rdata_q.py, va_q.py);
      dp1_q[2] <= tta_pkg::sat_sub(vtx_rdata_q.pz, va_q.pz);
      du1_q    <= tta_pkg::sat_sub(vtx_rdata_q.u, va_q.u);
      dv1_q    <= tta_pkg::sat_sub(vtx_rdata_q.v, va_q.v);
    end
    if (state_q == ST_RDD) begin
      dp2_q[0] <= tta_pkg::sat_sub(vtx_rdata_q.px, va_q.px);
      dp2_q[1] <= tta_pkg::sat_sub(vtx_rdata_q.py, va_q.py);
      dp2_q[2] <= tta_pkg::sat_sub(vtx_rdata_q.pz, va_q.pz);
      du2_q    <= tta_pkg::sat_sub(vtx_rdata_q.u, va_q.u);
      dv2_q    <= tta_pkg::sat_sub(vtx_rdata_q.v, va_q.v);
    end
    if (state_q == ST_MUL) begin
      prod_q <= op_a * op_b;
      if (m_q != 4'd0) begin
        if (!step[0]) begin
          first_q <= prod_q;
        end else begin
          term_q[step[3:1]] <= {first_q[63], first_q} - {prod_q[63], prod_q};
        end
      end
      if (m_q == 4'd14) begin
        deg_q <= term_q[0] == '0;
      end
    end
    if (state_q == ST_DIVW && div_done) begin
      res_q[j_q] <= div_quo;
    end
  end

endmodule
`default_nettype wire

// ===== sv/triangle_tangent_accumulator.sv =====
// Top level of the triangle tangent and bitangent accumulator.
`default_nettype none
// Requests enter a four-deep command queue and are carried out one at a time by the
// back end. A read waits for a free result register, and a triangle takes the
// command, reads the three vertices, forms fourteen products through one shared
// 32x32 multiplier, runs six serial divisions in one restoring divider (which sets
// the rate; a division whose quotient saturates early skips the serial steps), and
// does the read-modify-write of the three corners' accumulators. A zero determinant
// skips the divisions and only sets the corners' flags. Vertices must be loaded
// before use; the stores have no reset. The oldest result stays on the outputs while
// empty is low.
module triangle_tangent_accumulator (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [tta_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic [tta_pkg::IDX_W-1:0]            vertex_index_i,
  input  wire logic [tta_pkg::IDX_W-1:0]            corner_two_i,
  input  wire logic [tta_pkg::IDX_W-1:0]            corner_three_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0]    position_x_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0]    position_y_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0]    position_z_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0]    tex_u_i,
  input  wire logic signed [tta_pkg::DATA_W-1:0]    tex_v_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [tta_pkg::DATA_W-1:0]         tangent_x_o,
  output logic signed [tta_pkg::DATA_W-1:0]         tangent_y_o,
  output logic signed [tta_pkg::DATA_W-1:0]         tangent_z_o,
  output logic signed [tta_pkg::DATA_W-1:0]         bitangent_x_o,
  output logic signed [tta_pkg::DATA_W-1:0]         bitangent_y_o,
  output logic signed [tta_pkg::DATA_W-1:0]         bitangent_z_o,
  output logic                                      degenerate_seen_o
);

  tta_pkg::cmd_t cmd;
  tta_pkg::acc_t res;
  logic          cmd_valid, cmd_pop;

  tta_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .vertex_index_i (vertex_index_i),
    .corner_two_i   (corner_two_i),
    .corner_three_i (corner_three_i),
    .position_x_i   (position_x_i),
    .position_y_i   (position_y_i),
    .position_z_i   (position_z_i),
    .tex_u_i        (tex_u_i),
    .tex_v_i        (tex_v_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  tta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign tangent_x_o       = res.tx;
  assign tangent_y_o       = res.ty;
  assign tangent_z_o       = res.tz;
  assign bitangent_x_o     = res.bx;
  assign bitangent_y_o     = res.by;
  assign bitangent_z_o     = res.bz;
  assign degenerate_seen_o = res.flag;

endmodule
`default_nettype wire
